// File: design/lge_pkg.sv
// Package with the shared types, constants and arithmetic helpers of the loss and gradient engine.
package lge_pkg;

  // Vector storage depth and the widths that follow from it.
  localparam int MaxLen = 32;
  localparam int IdxW   = $clog2(MaxLen);
  localparam int CntW   = $clog2(MaxLen + 1);

  // Accumulator width and saturation bounds.
  localparam int AccW = 40;
  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  // ln(2) in Q16.
  localparam logic signed [21:0] Ln2Q16 = 22'sd45426;

  // Depth of the queue between the front and the back.
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Width of one stored (prediction, truth) pair.
  localparam int PairW = 30;

  typedef enum logic {
    KIND_MSE  = 1'b0,
    KIND_XENT = 1'b1
  } lge_kind_e;

  typedef struct packed {
    logic [14:0] prediction;
    logic [14:0] truth;
    logic        last;
  } lge_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_loss;
    logic [4:0]         index;
    logic               end_of_run;
  } lge_out_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic [14:0] prediction;
    logic [14:0] truth;
    logic        last;
    lge_kind_e   kind;
    logic        pred_zero;
    logic        truth_zero;
  } lge_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LN,
    ST_INT,
    ST_TERM,
    ST_ACC,
    ST_LOSS,
    ST_RD,
    ST_DIFF,
    ST_PLO,
    ST_PHI,
    ST_GRAD
  } lge_state_e;

  // Q16 table of ln(1 + k/16).
  function automatic logic [15:0] ln_lut(input logic [4:0] k);
    logic [15:0] v;
    unique case (k)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd3973;
      5'd2:    v = 16'd7719;
      5'd3:    v = 16'd11262;
      5'd4:    v = 16'd14624;
      5'd5:    v = 16'd17821;
      5'd6:    v = 16'd20870;
      5'd7:    v = 16'd23783;
      5'd8:    v = 16'd26573;
      5'd9:    v = 16'd29248;
      5'd10:   v = 16'd31818;
      5'd11:   v = 16'd34292;
      5'd12:   v = 16'd36675;
      5'd13:   v = 16'd38975;
      5'd14:   v = 16'd41196;
      5'd15:   v = 16'd43345;
      default: v = 16'd45426;
    endcase
    return v;
  endfunction

  // Saturate a grown sum to the accumulator range.
  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [AccW:0] x);
    logic signed [AccW-1:0] r;
    if (x > $signed({AccMax[AccW-1], AccMax})) begin
      r = AccMax;
    end else if (x < $signed({AccMin[AccW-1], AccMin})) begin
      r = AccMin;
    end else begin
      r = x[AccW-1:0];
    end
    return r;
  endfunction

  // Saturate to the signed 32-bit result range.
  function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x > 33'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -33'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: design/lge_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lge_ram #(
  parameter int Width = 8,
  parameter int Depth = 4,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lge_front.sv
// Front end: holds the loss kind register, takes input transfers and classifies them.
module lge_front import lge_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  lge_in_t    in_data_i,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       full_i,
  output logic       push_o,
  output lge_entry_t entry_o
);

  lge_kind_e kind_q;

  // Loss kind register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_MSE;
    end else if (cfg_we_i) begin
      kind_q <= lge_kind_e'(cfg_wdata_i);
    end
  end

  // Accept while the queue has room.
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

  // Tag each item with the kind in force and its zero flags.
  always_comb begin
    entry_o.prediction = in_data_i.prediction;
    entry_o.truth      = in_data_i.truth;
    entry_o.last       = in_data_i.last;
    entry_o.kind       = kind_q;
    entry_o.pred_zero  = (in_data_i.prediction == 15'd0);
    entry_o.truth_zero = (in_data_i.truth == 15'd0);
  end

endmodule

// File: design/lge_fifo.sv
// Short queue of classified items between the front end and the back end.
module lge_fifo import lge_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  lge_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output lge_entry_t entry_o
);

  lge_entry_t            mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: design/lge_back.sv
// Back end: accumulates the loss terms, then emits the loss and the gradients.
module lge_back import lge_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  lge_entry_t       entry_i,
  output logic             pop_o,
  output logic             ram_we_o,
  output logic [IdxW-1:0]  ram_waddr_o,
  output logic [PairW-1:0] ram_wdata_o,
  output logic [IdxW-1:0]  ram_raddr_o,
  input  logic [PairW-1:0] ram_rdata_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lge_out_t         out_data_o
);

  lge_state_e state_q, state_d;

  // Control state.
  logic [CntW-1:0]        n_q, n_d;
  logic [IdxW-1:0]        i_q, i_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [AccW-1:0] wes_q, wes_d;
  logic                   out_valid_q, out_valid_d;

  // Payload registers.
  lge_out_t           out_q, out_d;
  logic [14:0]        p_q, t_q;
  logic               last_q, pz_q, tz_q, store_q;
  lge_kind_e          kind_q, gkind_q;
  logic [3:0]         e_q;
  logic [15:0]        lo_q;
  logic [11:0]        slope_q;
  logic [9:0]         r_q;
  logic signed [31:0] dp_q;
  logic signed [20:0] ln_q;
  logic signed [36:0] term_q;
  logic signed [40:0] diff_q;
  logic [15:0]        pp2_q;
  logic signed [17:0] cg_q;
  logic [39:0]        plo_q;
  logic signed [33:0] phi_q;

  // Datapath intermediates.
  logic               slot_free;
  logic signed [15:0] d;
  logic [3:0]         lead;
  logic [14:0]        norm;
  logic [13:0]        frac;
  logic [15:0]        lo_v, hi_v;
  logic [22:0]        interp;
  logic signed [4:0]  em14;
  logic signed [21:0] ln_sum;
  logic signed [15:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [36:0] prod;
  logic signed [40:0] lsum, lsh;
  logic [14:0]        rd_p, rd_t;
  logic signed [58:0] gsum;
  logic signed [32:0] gval;
  logic               grad_end;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign ram_raddr_o = i_q;
  assign ram_waddr_o = n_q[IdxW-1:0];
  assign ram_wdata_o = {entry_i.prediction, entry_i.truth};
  assign rd_p        = ram_rdata_i[29:15];
  assign rd_t        = ram_rdata_i[14:0];
  assign grad_end    = ((CntW'(i_q) + 1'b1) == n_q);

  // Leading-one position and table lookup of the normalized mantissa.
  always_comb begin
    lead = 4'd0;
    for (int b = 1; b < 15; b++) begin
      if (p_q[b]) begin
        lead = 4'(b);
      end
    end
    norm   = 15'(p_q << (4'd14 - lead));
    frac   = norm[13:0];
    lo_v   = ln_lut({1'b0, frac[13:10]});
    hi_v   = ln_lut(5'({1'b0, frac[13:10]} + 5'd1));
    d      = $signed({1'b0, t_q}) - $signed({1'b0, p_q});
  end

  // Interpolation, exponent term and the shared loss multiplier.
  always_comb begin
    interp = (23'(slope_q) * 23'(r_q) + 23'd512) >> 10;
    em14   = $signed({1'b0, e_q}) - 5'sd14;
    ln_sum = 22'(em14) * Ln2Q16 + $signed({6'd0, lo_q}) + $signed({9'd0, interp[12:0]});
    mul_a  = (kind_q == KIND_XENT) ? -$signed({1'b0, t_q}) : d;
    mul_b  = (kind_q == KIND_XENT) ? ln_q : 21'(d);
    prod   = 37'(mul_a) * 37'(mul_b);
  end

  // Loss rounding and gradient assembly.
  always_comb begin
    lsum = 41'(acc_q) + 41'sd2048;
    lsh  = lsum >>> 12;
    gsum = (59'(phi_q) <<< 24) + $signed({19'd0, plo_q}) + (59'sd1 <<< 25);
    if (gkind_q == KIND_MSE) begin
      gval = gsum[58:26];
    end else begin
      gval = 33'(cg_q);
    end
  end

  // Sequencer: next state and control updates.
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    i_d         = i_q;
    acc_d       = acc_q;
    wes_d       = wes_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    ram_we_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          ram_we_o = (n_q < CntW'(MaxLen));
          state_d  = ST_LN;
        end
      end
      ST_LN:   state_d = ST_INT;
      ST_INT:  state_d = ST_TERM;
      ST_TERM: state_d = ST_ACC;
      ST_ACC: begin
        if (store_q) begin
          n_d   = n_q + 1'b1;
          wes_d = sat_acc(41'(wes_q) + 41'(dp_q));
          if (kind_q == KIND_XENT && pz_q) begin
            if (!tz_q) begin
              acc_d = AccMax;
            end
          end else begin
            acc_d = sat_acc(41'(acc_q) + 41'(term_q));
          end
        end
        state_d = last_q ? ST_LOSS : ST_IDLE;
      end
      ST_LOSS: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.value      = lsh[31:0];
          out_d.is_loss    = 1'b1;
          out_d.index      = 5'd0;
          out_d.end_of_run = (n_q == '0);
          i_d              = '0;
          if (n_q == '0) begin
            acc_d   = '0;
            wes_d   = '0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD:   state_d = ST_DIFF;
      ST_DIFF: state_d = ST_PLO;
      ST_PLO:  state_d = ST_PHI;
      ST_PHI:  state_d = ST_GRAD;
      ST_GRAD: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.value      = sat32(gval);
          out_d.is_loss    = 1'b0;
          out_d.index      = 5'(i_q);
          out_d.end_of_run = grad_end;
          if (grad_end) begin
            n_d     = '0;
            acc_d   = '0;
            wes_d   = '0;
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      i_q         <= '0;
      acc_q       <= '0;
      wes_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      i_q         <= i_d;
      acc_q       <= acc_d;
      wes_q       <= wes_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers, loaded in the state that produces each value.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (pop_o) begin
      p_q     <= entry_i.prediction;
      t_q     <= entry_i.truth;
      last_q  <= entry_i.last;
      kind_q  <= entry_i.kind;
      pz_q    <= entry_i.pred_zero;
      tz_q    <= entry_i.truth_zero;
      store_q <= (n_q < CntW'(MaxLen));
    end
    if (state_q == ST_LN) begin
      e_q     <= lead;
      lo_q    <= lo_v;
      slope_q <= 12'(hi_v - lo_v);
      r_q     <= frac[9:0];
      dp_q    <= 32'(d) * $signed({17'd0, p_q});
    end
    if (state_q == ST_INT) begin
      ln_q <= ln_sum[20:0];
    end
    if (state_q == ST_TERM) begin
      term_q <= (kind_q == KIND_XENT) ? ((prod + 37'sd2) >>> 2) : prod;
    end
    if (state_q == ST_ACC && last_q) begin
      gkind_q <= kind_q;
    end
    if (state_q == ST_DIFF) begin
      diff_q <= (41'($signed({1'b0, rd_t}) - $signed({1'b0, rd_p})) <<< 14) - 41'(wes_q);
      pp2_q  <= {rd_p, 1'b0};
      cg_q   <= 18'($signed({1'b0, rd_p}) - $signed({1'b0, rd_t})) <<< 2;
    end
    if (state_q == ST_PLO) begin
      plo_q <= 40'(diff_q[23:0]) * 40'(pp2_q);
    end
    if (state_q == ST_PHI) begin
      phi_q <= 34'($signed(diff_q[40:24])) * $signed({18'd0, pp2_q});
    end
  end

endmodule

// File: design/loss_and_gradient_engine.sv
// Top level of the loss and gradient engine.
//
// Items (prediction, truth, last) in Q1.14 are taken through a two-entry queue
// and processed by the back end one at a time in the steps pop, leading-one
// search with ln table lookup, interpolation, one shared multiplier and
// accumulate; the next item is popped only after the accumulate step. Up to
// 32 pairs are kept in a small RAM. After the item marked last the block emits
// the loss, then one gradient per stored element (RAM read, difference, two
// partial products of the wide multiply, round and saturate), each result
// waiting while the output side stalls. The loss kind register may be written
// only while no run is in progress; there is no clearing pass after reset.
module loss_and_gradient_engine import lge_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lge_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lge_out_t out_data_o,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i
);

  logic             push, pop, full, empty;
  lge_entry_t       push_entry, pop_entry;
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [PairW-1:0] ram_wdata, ram_rdata;

  // Front end: register and classification.
  lge_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Queue between front and back.
  lge_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .entry_o(pop_entry)
  );

  // Pair storage.
  lge_ram #(
    .Width(PairW),
    .Depth(MaxLen)
  ) u_pair_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Back end: accumulation and result generation.
  lge_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .entry_i    (pop_entry),
    .pop_o      (pop),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
